/* src/jlbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbl_pkg
// Shared types, constants and helpers of the joint limit braking limiter.
// ----------------------------------------------------------------------------
package jlbl_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_DATA_W = 3 * WORD_W;
	localparam int unsigned SQRT_STEPS = WORD_W;
	localparam int unsigned SQRT_CNT_W = $clog2(SQRT_STEPS);

	localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;

	localparam logic [WORD_W-1:0] SPEED_COEFF_RST = 32'd65536;
	localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_LIMIT    = 2'd0,
		REG_UPPER_LIMIT    = 2'd1,
		REG_DISTANCE_COEFF = 2'd2,
		REG_SPEED_COEFF    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_SQUARE = 2'd0,
		MUL_LO     = 2'd1,
		MUL_HI     = 2'd2,
		MUL_BRAKE  = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     dist_en;
		logic     thr_en;
		logic     decide_en;
		logic     sqrt_step;
		logic     round_en;
		logic     out_load;
	} jlbl_cmd_t;

	typedef struct packed {
		logic velocity;
		logic update;
		logic need_sqrt;
		logic sqrt_done;
		logic out_free;
	} jlbl_status_t;

	// saturate a 33-bit signed sum to 32 bits
	function automatic logic signed [WORD_W-1:0] sat33(input logic signed [WORD_W:0] s);
		logic signed [WORD_W-1:0] r;
		if (s[WORD_W] != s[WORD_W-1]) begin
			r = s[WORD_W] ? INT_MIN : INT_MAX;
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/jlbl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbl_ctrl
// Sequencer of the limiter: steps the datapath through threshold update,
// decision, braking speed product and square root.
// ----------------------------------------------------------------------------
module jlbl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  jlbl_pkg::jlbl_status_t status,
	output jlbl_pkg::jlbl_cmd_t    cmd
);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_CHECK   = 12'b0000_0000_0010,
		ST_SQUARE  = 12'b0000_0000_0100,
		ST_MUL_LO  = 12'b0000_0000_1000,
		ST_MUL_HI  = 12'b0000_0001_0000,
		ST_DIST    = 12'b0000_0010_0000,
		ST_THRESH  = 12'b0000_0100_0000,
		ST_DECIDE  = 12'b0000_1000_0000,
		ST_BRK_MUL = 12'b0001_0000_0000,
		ST_SQRT    = 12'b0010_0000_0000,
		ST_ROUND   = 12'b0100_0000_0000,
		ST_OUT     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.mul_sel   = jlbl_pkg::MUL_SQUARE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.velocity) begin
					state_nxt = ST_OUT;
				end else if (status.update) begin
					state_nxt = ST_SQUARE;
				end else begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_SQUARE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jlbl_pkg::MUL_SQUARE;
				state_nxt   = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jlbl_pkg::MUL_LO;
				state_nxt   = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jlbl_pkg::MUL_HI;
				state_nxt   = ST_DIST;
			end
			ST_DIST: begin
				cmd.dist_en = 1'b1;
				state_nxt   = ST_THRESH;
			end
			ST_THRESH: begin
				cmd.thr_en = 1'b1;
				state_nxt  = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide_en = 1'b1;
				state_nxt     = status.need_sqrt ? ST_BRK_MUL : ST_OUT;
			end
			ST_BRK_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = jlbl_pkg::MUL_BRAKE;
				state_nxt   = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_done) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				state_nxt    = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/jlbl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbl_dp
// Datapath of the limiter: configuration registers, shared 32x32 multiplier,
// threshold state, decision logic, bit-pair square root and output register.
// ----------------------------------------------------------------------------
module jlbl_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	input  logic [jlbl_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [jlbl_pkg::WORD_W-1:0]             cfg_data,
	input  logic [jlbl_pkg::IN_DATA_W-1:0]          s_tdata,
	input  logic [jlbl_pkg::MODE_W-1:0]             s_tuser,
	output logic [jlbl_pkg::WORD_W-1:0]             m_tdata,
	output logic                                    m_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	input  jlbl_pkg::jlbl_cmd_t                     cmd,
	output jlbl_pkg::jlbl_status_t                  status
);

	localparam int unsigned W = jlbl_pkg::WORD_W;

	// configuration
	logic signed [W-1:0] lower_limit_q;
	logic signed [W-1:0] upper_limit_q;
	logic [W-1:0]        distance_coeff_q;
	logic [W-1:0]        speed_coeff_q;

	// item
	logic signed [W-1:0]            pos_q;
	logic signed [W-1:0]            cmd_q;
	logic [W-1:0]                   mag_q;
	logic [jlbl_pkg::MODE_W-1:0]    mode_q;

	// state
	logic                braking_active_q;
	logic signed [W-1:0] lower_thr_q;
	logic signed [W-1:0] upper_thr_q;

	// working registers
	logic [2*W-1:0] sq_q;
	logic [2*W-1:0] p0_q;
	logic [2*W-1:0] p1_q;
	logic [W-2:0]   dist_q;
	logic [W-1:0]   d_q;
	logic           neg_q;
	logic [2*W-1:0] rad_q;
	logic [W+1:0]   rem_q;
	logic [W-1:0]   root_q;
	logic [jlbl_pkg::SQRT_CNT_W-1:0] cnt_q;
	logic signed [W-1:0] drive_q;
	logic                brk_q;
	logic                m_valid_q;

	// multiplier
	logic [W-1:0]   mul_a;
	logic [W-1:0]   mul_b;
	logic [2*W-1:0] prod;

	always_comb begin
		case (cmd.mul_sel)
			jlbl_pkg::MUL_SQUARE: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			jlbl_pkg::MUL_LO: begin
				mul_a = sq_q[W-1:0];
				mul_b = distance_coeff_q;
			end
			jlbl_pkg::MUL_HI: begin
				mul_a = sq_q[2*W-1:W];
				mul_b = distance_coeff_q;
			end
			jlbl_pkg::MUL_BRAKE: begin
				mul_a = d_q;
				mul_b = speed_coeff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = (2*W)'(mul_a) * (2*W)'(mul_b);

	// braking distance, saturated to the positive signed range
	logic [3*W-1:0] dist_sum;
	logic [W-2:0]   dist_nxt;

	assign dist_sum = {{W{1'b0}}, p0_q} + {p1_q, {W{1'b0}}};
	assign dist_nxt = (|dist_sum[3*W-1:W+W/2-1]) ? {(W-1){1'b1}} :
		dist_sum[W+W/2-2:W/2];

	// thresholds
	logic signed [W:0] lt_sum;
	logic signed [W:0] ut_sum;

	assign lt_sum = {lower_limit_q[W-1], lower_limit_q} + {2'b00, dist_q};
	assign ut_sum = {upper_limit_q[W-1], upper_limit_q} - {2'b00, dist_q};

	// decision
	logic cmd_pos;
	logic cmd_neg;
	logic below_thr;
	logic above_thr;
	logic brake_cond;
	logic outside;
	logic brake_zero;

	assign cmd_neg    = cmd_q[W-1];
	assign cmd_pos    = !cmd_q[W-1] && (cmd_q != '0);
	assign below_thr  = pos_q < lower_thr_q;
	assign above_thr  = pos_q > upper_thr_q;
	assign brake_cond = (below_thr && !cmd_pos) || (above_thr && !cmd_neg);
	assign outside    = (pos_q <= lower_limit_q) || (pos_q >= upper_limit_q);
	assign brake_zero = outside || (!below_thr && !above_thr);

	// square root step
	logic [W+3:0] sq_r2;
	logic [W+3:0] sq_trial;
	logic [W+3:0] sq_diff;

	assign sq_r2    = {rem_q, rad_q[2*W-1:2*W-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_diff  = sq_r2 - sq_trial;

	// rounding
	logic [W:0]     round_sum;
	logic [W-8:0]   round_v;
	logic [W-1:0]   round_ext;

	assign round_sum = {1'b0, root_q} + (W+1)'(128);
	assign round_v   = round_sum[W:8];
	assign round_ext = {7'b0, round_v};

	assign status.velocity  = (mode_q == jlbl_pkg::MODE_VELOCITY);
	assign status.update    = !braking_active_q;
	assign status.need_sqrt = brake_cond && !brake_zero;
	assign status.sqrt_done = (cnt_q == jlbl_pkg::SQRT_CNT_W'(jlbl_pkg::SQRT_STEPS - 1));
	assign status.out_free  = !m_valid_q || m_tready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_limit_q    <= '0;
			upper_limit_q    <= '0;
			distance_coeff_q <= '0;
			speed_coeff_q    <= jlbl_pkg::SPEED_COEFF_RST;
			braking_active_q <= 1'b0;
			lower_thr_q      <= '0;
			upper_thr_q      <= '0;
			m_valid_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					jlbl_pkg::REG_LOWER_LIMIT:    lower_limit_q    <= cfg_data;
					jlbl_pkg::REG_UPPER_LIMIT:    upper_limit_q    <= cfg_data;
					jlbl_pkg::REG_DISTANCE_COEFF: distance_coeff_q <= cfg_data;
					jlbl_pkg::REG_SPEED_COEFF:    speed_coeff_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.thr_en) begin
				lower_thr_q <= jlbl_pkg::sat33(lt_sum);
				upper_thr_q <= jlbl_pkg::sat33(ut_sum);
			end
			if (cmd.decide_en) begin
				braking_active_q <= brake_cond;
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pos_q   <= s_tdata[W-1:0];
			cmd_q   <= s_tdata[3*W-1:2*W];
			mode_q  <= s_tuser;
			mag_q   <= s_tdata[2*W-1] ? (W'(0) - s_tdata[2*W-1:W]) : s_tdata[2*W-1:W];
			drive_q <= s_tdata[3*W-1:2*W];
			brk_q   <= 1'b0;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				jlbl_pkg::MUL_SQUARE: sq_q <= prod;
				jlbl_pkg::MUL_LO:     p0_q <= prod;
				jlbl_pkg::MUL_HI:     p1_q <= prod;
				jlbl_pkg::MUL_BRAKE: begin
					rad_q  <= prod;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.dist_en) begin
			dist_q <= dist_nxt;
		end
		if (cmd.decide_en) begin
			if (brake_cond) begin
				brk_q   <= 1'b1;
				drive_q <= '0;
			end
			neg_q <= below_thr;
			d_q   <= below_thr ? W'(pos_q - lower_limit_q) : W'(upper_limit_q - pos_q);
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[2*W-3:0], 2'b00};
			cnt_q <= cnt_q + 1'b1;
			if (!sq_diff[W+3]) begin
				rem_q  <= sq_diff[W+1:0];
				root_q <= {root_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= sq_r2[W+1:0];
				root_q <= {root_q[W-2:0], 1'b0};
			end
		end
		if (cmd.round_en) begin
			drive_q <= neg_q ? (W'(0) - round_ext) : round_ext;
		end
		if (cmd.out_load) begin
			m_tdata <= drive_q;
			m_tuser <= brk_q;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

/* src/joint_limit_braking_limiter.sv */
`timescale 1ns / 1ps
// Non-velocity items go from the check state straight to the output register. Velocity
// items recompute the thresholds while braking is inactive, then decide, and when a braking
// speed is needed run the 32-step square root (one result bit per cycle) and rounding.
// One item at a time: the next is taken once the result is in the output register.
// reset: arst_n clears limits, distance coefficient, thresholds and braking flag,
// speed coefficient returns to 1.0 in q16.16
// ----------------------------------------------------------------------------
// joint_limit_braking_limiter
// Replaces a velocity command by a braking speed near the joint limits.
// ----------------------------------------------------------------------------
module joint_limit_braking_limiter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jlbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jlbl_pkg::WORD_W-1:0]        cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [jlbl_pkg::IN_DATA_W-1:0]     s_tdata,  // actual_position, actual_speed, command_value
	input  logic [jlbl_pkg::MODE_W-1:0]        s_tuser,  // mode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [jlbl_pkg::WORD_W-1:0]        m_tdata,  // drive_value
	output logic                               m_tuser   // braking
);

	jlbl_pkg::jlbl_cmd_t    cmd;
	jlbl_pkg::jlbl_status_t status;
	logic                   cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	jlbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	jlbl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* tb/sv/joint_limit_braking_limiter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_limit_braking_limiter_test
// Self-checking bench for the braking limiter. Position, speed, mode and
// command transfers go in with random gaps. Each result is compared in order
// with a local prediction of the drive value and braking flag. Limits and
// coefficients are reloaded between phases, from directed corner settings
// to random ones, and a long output stall fills the block once.
// ----------------------------------------------------------------------------
module joint_limit_braking_limiter_test;
	import jlbl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURRENT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OTHER    = 2'd3;
	localparam int RANDOM_ITEMS = 1840;
	localparam int RANDOM_PHASES = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX = 10;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [WORD_W-1:0] position;
		logic signed [WORD_W-1:0] speed;
		logic [MODE_W-1:0]        mode;
		logic signed [WORD_W-1:0] command;
	} joint_sample_t;

	typedef struct {
		logic [WORD_W-1:0] drive;
		logic              braking;
	} drive_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [MODE_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [WORD_W-1:0]    m_tdata;
	logic                 m_tuser;

	logic signed [WORD_W-1:0] lim_lower;
	logic signed [WORD_W-1:0] lim_upper;
	logic signed [WORD_W-1:0] thr_lower;
	logic signed [WORD_W-1:0] thr_upper;
	logic [WORD_W-1:0]        coeff_dist;
	logic [WORD_W-1:0]        coeff_speed;
	logic                     brake_latched;

	drive_result_t expected_drive_q[$];
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int braking_seen = 0;
	int cfg_writes = 0;
	int cycle_count = 0;
	bit jitter_on;
	bit hold_req;

	joint_limit_braking_limiter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_drive_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint clamp32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] floor_root(input logic [63:0] x);
		logic [WORD_W-1:0] r;
		logic [WORD_W-1:0] trial;
		r = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			trial = r | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= x) r = trial;
		end
		return r;
	endfunction

	function automatic longint brake_distance(input logic signed [WORD_W-1:0] spd);
		logic [63:0] mag;
		logic [95:0] prod;
		mag = (spd < 0) ? 64'(-longint'(spd)) : 64'(longint'(spd));
		prod = 96'(mag * mag) * 96'(coeff_dist);
		if (prod[95:16] > 80'h7fff_ffff) return S32_MAX;
		return longint'(prod[46:16]);
	endfunction

	function automatic longint braking_speed(input longint pos);
		longint lo;
		longint hi;
		longint mag;
		logic [WORD_W-1:0] gap;
		lo = longint'(lim_lower);
		hi = longint'(lim_upper);
		if (pos <= lo || pos >= hi) return 0;
		// lower side is tested first, as in the block
		if (pos < longint'(thr_lower)) gap = 32'(pos - lo);
		else if (pos > longint'(thr_upper)) gap = 32'(hi - pos);
		else return 0;
		mag = (longint'({32'd0, floor_root(64'(gap) * 64'(coeff_speed))}) + 128) >> 8;
		return (pos < longint'(thr_lower)) ? -mag : mag;
	endfunction

	task automatic limit_drive(input joint_sample_t smp, output drive_result_t res);
		longint pos;
		longint cmd;
		longint brake_len;
		pos = longint'(smp.position);
		cmd = longint'(smp.command);
		res.drive = smp.command;
		res.braking = 1'b0;
		if (smp.mode == MODE_VELOCITY) begin
			if (!brake_latched) begin
				brake_len = brake_distance(smp.speed);
				thr_lower = 32'(clamp32(longint'(lim_lower) + brake_len));
				thr_upper = 32'(clamp32(longint'(lim_upper) - brake_len));
			end
			if ((pos < longint'(thr_lower) && cmd <= 0) ||
					(pos > longint'(thr_upper) && cmd >= 0)) begin
				res.drive = 32'(braking_speed(pos));
				res.braking = 1'b1;
				brake_latched = 1'b1;
			end else begin
				brake_latched = 1'b0;
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic longint rand_mag();
		return longint'($urandom()) >> $urandom_range(0, 32);
	endfunction

	function automatic joint_sample_t make_sample(input logic signed [WORD_W-1:0] pos, spd,
			input logic [MODE_W-1:0] mode, input logic signed [WORD_W-1:0] cmd);
		joint_sample_t smp;
		smp.position = pos;
		smp.speed = spd;
		smp.mode = mode;
		smp.command = cmd;
		return smp;
	endfunction

	task automatic flag_field(input string field, input longint expv, input longint gotv);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s expected %0d, got %0d", $time, field, expv, gotv);
	endtask

	always @(posedge clk) begin : result_check
		drive_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser) braking_seen++;
			if (expected_drive_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: unexpected result, drive_value %0d braking %b", $time,
						$signed(m_tdata), m_tuser);
			end else begin
				exp_res = expected_drive_q.pop_front();
				if (m_tdata !== exp_res.drive)
					flag_field("drive_value", longint'($signed(exp_res.drive)),
						longint'($signed(m_tdata)));
				if (m_tuser !== exp_res.braking)
					flag_field("braking", longint'(exp_res.braking), longint'(m_tuser));
			end
		end
	end

	initial begin : result_sink
		int wait_n;
		int run_n;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				wait_n = jitter_on ? pick_gap() : 0;
				if (wait_n > 0) begin
					m_tready <= 1'b0;
					repeat (wait_n) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			run_n = jitter_on ? $urandom_range(1, 12) : 1;
			repeat (run_n) @(posedge clk);
		end
	end

	task automatic send_sample(input joint_sample_t smp);
		int gap_n;
		drive_result_t res;
		gap_n = jitter_on ? pick_gap() : 0;
		if (gap_n > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {smp.command, smp.speed, smp.position};
		s_tuser <= smp.mode;
		do @(posedge clk); while (!s_tready);
		limit_drive(smp, res);
		expected_drive_q.push_back(res);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOWER_LIMIT:    lim_lower = val;
			REG_UPPER_LIMIT:    lim_upper = val;
			REG_DISTANCE_COEFF: coeff_dist = val;
			REG_SPEED_COEFF:    coeff_speed = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic load_config(input logic signed [WORD_W-1:0] lo, hi,
			input logic [WORD_W-1:0] dc, sc);
		drain();
		write_reg(REG_LOWER_LIMIT, lo);
		write_reg(REG_UPPER_LIMIT, hi);
		write_reg(REG_DISTANCE_COEFF, dc);
		write_reg(REG_SPEED_COEFF, sc);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic approach_run();
		int len;
		int r;
		bit to_upper;
		longint pos;
		longint step;
		longint spd;
		longint cmd;
		len = $urandom_range(4, 16);
		to_upper = ($urandom_range(0, 1) == 1);
		step = (rand_mag() >> $urandom_range(0, 4)) + $urandom_range(0, 3);
		pos = to_upper ? clamp32(longint'(lim_upper) - rand_mag())
			: clamp32(longint'(lim_lower) + rand_mag());
		spd = rand_mag();
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			cmd = rand_mag();
			if (r < 7) cmd = to_upper ? cmd : -cmd;
			else if (r < 9) cmd = to_upper ? -cmd : cmd;
			else cmd = 0;
			spd = clamp32(spd + $urandom_range(0, 8) - 4);
			send_sample(make_sample(32'(pos), 32'(to_upper ? spd : -spd), MODE_VELOCITY,
				32'(clamp32(cmd))));
			pos = clamp32(to_upper ? pos + step : pos - step);
		end
	endtask

	task automatic noise_item();
		send_sample(make_sample($urandom(), $urandom(), 2'($urandom_range(0, 3)),
			$urandom()));
	endtask

	task automatic test_reset_state();
		send_sample(make_sample(-32'sd5, 32'sd0, MODE_VELOCITY, -32'sd3));
		send_sample(make_sample(32'sd5, 32'sd9, MODE_VELOCITY, 32'sd7));
		send_sample(make_sample(32'sd1, 32'sd1, MODE_POSITION, INT_MIN));
	endtask

	task automatic test_directed_limits();
		load_config(-32'sd100000, 32'sd100000, 32'h0000_4000, SPEED_COEFF_RST);
		send_sample(make_sample(INT_MAX, INT_MIN, MODE_POSITION, INT_MAX));
		send_sample(make_sample(INT_MIN, 32'sd0, MODE_CURRENT, INT_MIN));
		send_sample(make_sample(32'sd0, INT_MAX, MODE_OTHER, -32'sd1));
		send_sample(make_sample(32'sd0, 32'sd200, MODE_VELOCITY, 32'sd500));
		send_sample(make_sample(-32'sd95000, -32'sd200, MODE_VELOCITY, -32'sd300));
		send_sample(make_sample(-32'sd96000, 32'sd5000, MODE_VELOCITY, -32'sd300));
		send_sample(make_sample(-32'sd96000, 32'sd200, MODE_VELOCITY, 32'sd50));
		send_sample(make_sample(32'sd95000, 32'sd200, MODE_VELOCITY, 32'sd300));
		send_sample(make_sample(32'sd95000, 32'sd200, MODE_VELOCITY, -32'sd1));
		send_sample(make_sample(32'sd100000, 32'sd200, MODE_VELOCITY, 32'sd5));
		send_sample(make_sample(-32'sd100001, 32'sd0, MODE_VELOCITY, 32'sd0));
		send_sample(make_sample(INT_MIN, INT_MIN, MODE_VELOCITY, INT_MIN));
		send_sample(make_sample(INT_MAX, INT_MAX, MODE_VELOCITY, INT_MAX));
		send_sample(make_sample(32'sd0, 32'sd0, MODE_VELOCITY, 32'sd0));
	endtask

	task automatic test_overlapping_thresholds();
		load_config(-32'sd100, 32'sd100, 32'h000a_0000, SPEED_COEFF_RST);
		send_sample(make_sample(32'sd50, 32'sd100, MODE_VELOCITY, 32'sd5));
		send_sample(make_sample(-32'sd50, 32'sd100, MODE_VELOCITY, -32'sd5));
		send_sample(make_sample(32'sd99, 32'sd100, MODE_VELOCITY, 32'sd0));
	endtask

	task automatic test_saturation();
		load_config(32'sh7fff_fff5, 32'sh8000_000a, 32'hffff_ffff, 32'hffff_ffff);
		send_sample(make_sample(32'sd0, INT_MIN, MODE_VELOCITY, 32'sd0));
		send_sample(make_sample(INT_MAX, 32'sd1, MODE_VELOCITY, INT_MAX));
		load_config(INT_MIN, INT_MAX, 32'hffff_ffff, 32'hffff_ffff);
		send_sample(make_sample(32'sh8000_0001, INT_MIN, MODE_VELOCITY, 32'sd0));
		send_sample(make_sample(32'sh7fff_fff0, 32'sd0, MODE_VELOCITY, 32'sd1));
		load_config(INT_MIN, INT_MAX, 32'd0, 32'd0);
		send_sample(make_sample(32'sd5, 32'sd3, MODE_VELOCITY, 32'sd7));
	endtask

	task automatic test_output_stall();
		load_config(-32'sd50000, 32'sd50000, 32'h0001_0000, SPEED_COEFF_RST);
		jitter_on = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 4; i++) approach_run();
		drain();
		jitter_on = 1'b1;
	endtask

	task automatic random_config(input int phase);
		longint lo;
		longint hi;
		longint span;
		logic [WORD_W-1:0] dc;
		logic [WORD_W-1:0] sc;
		case (phase)
			0: load_config(INT_MIN, INT_MAX, 32'hffff_ffff, 32'hffff_ffff);
			1: load_config(INT_MAX, INT_MIN, 32'd0, 32'd0);
			2: load_config(32'sd0, 32'sd0, 32'hffff_ffff, SPEED_COEFF_RST);
			default: begin
				lo = longint'($signed($urandom())) >>> $urandom_range(0, 31);
				span = rand_mag();
				hi = ($urandom_range(0, 7) == 0) ? clamp32(lo - span) : clamp32(lo + span);
				dc = $urandom() >> $urandom_range(0, 32);
				sc = $urandom() >> $urandom_range(0, 32);
				load_config(32'(lo), 32'(hi), dc, sc);
			end
		endcase
	endtask

	task automatic test_random_phases();
		int phase_target;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config(phase);
			jitter_on = (phase % 4 != 3);
			phase_target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (items_sent < phase_target) begin
				if ($urandom_range(0, 99) < 75) approach_run();
				else noise_item();
			end
		end
		jitter_on = 1'b1;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOWER_LIMIT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_POSITION;
		lim_lower = '0;
		lim_upper = '0;
		coeff_dist = '0;
		coeff_speed = SPEED_COEFF_RST;
		thr_lower = '0;
		thr_upper = '0;
		brake_latched = 1'b0;
		jitter_on = 1'b1;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_limits();
		test_overlapping_thresholds();
		test_saturation();
		test_output_stall();
		test_random_phases();

		drain();
		repeat (50) @(posedge clk);
		$display("run: %0d transfers in, %0d results out (%0d braking), %0d register writes",
			items_sent, results_seen, braking_seen, cfg_writes);
		$display("run: %0d mismatches in %0d cycles", fail_count, cycle_count);
		if (fail_count == 0 && expected_drive_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
